[sv/bsed_pkg.sv]
package bsed_pkg;

  localparam int         FrameWidthDefault = 256;
  localparam logic [7:0] ThresholdReset    = 8'd127;
  localparam logic [7:0] PixelWhite        = 8'd255;
  localparam logic [7:0] PixelBlack        = 8'd0;

  // Which sides of a 3x3 window fall outside the frame.
  typedef struct packed {
    logic top;
    logic bottom;
    logic left;
    logic right;
  } border_t;

  // Window bit index is 3*row + col, row 0 on top, col 0 on the left.
  function automatic logic [8:0] mask_window(logic [8:0] win, border_t bord);
    logic [8:0] res;
    res = win;
    if (bord.top) begin
      res[2:0] = 3'b000;
    end
    if (bord.bottom) begin
      res[8:6] = 3'b000;
    end
    if (bord.left) begin
      res[0] = 1'b0;
      res[3] = 1'b0;
      res[6] = 1'b0;
    end
    if (bord.right) begin
      res[2] = 1'b0;
      res[5] = 1'b0;
      res[8] = 1'b0;
    end
    return res;
  endfunction

  // Nonzero Sobel X or Y gradient on a binary window.
  function automatic logic sobel_nonzero(logic [8:0] p);
    logic [2:0] x_left;
    logic [2:0] x_right;
    logic [2:0] y_top;
    logic [2:0] y_bottom;
    x_left   = 3'(p[0]) + 3'({p[3], 1'b0}) + 3'(p[6]);
    x_right  = 3'(p[2]) + 3'({p[5], 1'b0}) + 3'(p[8]);
    y_top    = 3'(p[0]) + 3'({p[1], 1'b0}) + 3'(p[2]);
    y_bottom = 3'(p[6]) + 3'({p[7], 1'b0}) + 3'(p[8]);
    return (x_left != x_right) || (y_top != y_bottom);
  endfunction

endpackage

[sv/bsed_line_store.sv]
module bsed_line_store
  import bsed_pkg::*;
#(
  parameter int Depth = FrameWidthDefault,
  localparam int AddrW = $clog2(Depth)
) (
  input  logic             clk_i,
  input  logic             rd_en_i,
  input  logic [AddrW-1:0] rd_addr_i,
  output logic [1:0]       rd_data_o,
  input  logic             wr_en_i,
  input  logic [AddrW-1:0] wr_addr_i,
  input  logic [1:0]       wr_data_i
);

  // One entry per column: bit 1 two rows back, bit 0 one row back.
  logic [1:0] mem_q [Depth];
  logic [1:0] rd_data_q;

  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      mem_q[wr_addr_i] <= wr_data_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (rd_en_i) begin
      rd_data_q <= mem_q[rd_addr_i];
    end
  end

  assign rd_data_o = rd_data_q;

endmodule

[sv/binary_sobel_edge_detect_top.sv]
// Channel   Dir  Handshake                     Payload
// cfg       in   cfg_valid_i / cfg_ready_o     cfg_data_i: binarize threshold
// s_axis    in   s_axis_tvalid / tready        tdata: pixel_in, tuser: pad
// m_axis    out  m_axis_tvalid / tready        tdata: pixel_out, tlast: out_last
//
// One item per cycle sustained while m_axis accepts; each item passes three register
// stages (input stage with the binary line store read, window stage with the edge
// line store read, output register), as each line store read is registered.
// A result appears for the item 2*FRAME_WIDTH+2 places after its pixel.
// Reset clears control state and sets the threshold to 127; line stores are not
// cleared, and entries from a previous frame are masked at the frame borders.
// A stall on m_axis holds all stages and drops s_axis_tready once they are full.
module binary_sobel_edge_detect_top
  import bsed_pkg::*;
#(
  parameter int FRAME_WIDTH = FrameWidthDefault
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  // Configuration write
  input  logic       cfg_valid_i,
  output logic       cfg_ready_o,
  input  logic [7:0] cfg_data_i,
  // Pixel stream in
  input  logic       s_axis_tvalid,
  output logic       s_axis_tready,
  input  logic [7:0] s_axis_tdata,   // [7:0] pixel_in
  input  logic       s_axis_tuser,   // [0] pad
  // Pixel stream out
  output logic       m_axis_tvalid,
  input  logic       m_axis_tready,
  output logic [7:0] m_axis_tdata,   // [7:0] pixel_out
  output logic       m_axis_tlast
);

  localparam int ColW = $clog2(FRAME_WIDTH);
  localparam int RowW = $clog2(FRAME_WIDTH + 3);

  localparam logic [ColW-1:0] ColLast  = ColW'(FRAME_WIDTH - 1);
  localparam logic [ColW-1:0] ColOne   = ColW'(1);
  localparam logic [ColW-1:0] ColTwo   = ColW'(2);
  localparam logic [RowW-1:0] RowOne   = RowW'(1);
  localparam logic [RowW-1:0] RowTwo   = RowW'(2);
  localparam logic [RowW-1:0] RowThree = RowW'(3);
  // First row past the frame, the one after it, and the last flush row.
  localparam logic [RowW-1:0] RowPast  = RowW'(FRAME_WIDTH);
  localparam logic [RowW-1:0] RowBelow = RowW'(FRAME_WIDTH + 1);
  localparam logic [RowW-1:0] RowEnd   = RowW'(FRAME_WIDTH + 2);

  // ---------------------------------------------------------------------------
  // Threshold register
  // ---------------------------------------------------------------------------
  logic [7:0] thresh_q;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      thresh_q <= ThresholdReset;
    end else if (cfg_valid_i) begin
      thresh_q <= cfg_data_i;
    end
  end

  // ---------------------------------------------------------------------------
  // Handshake and stage advance
  // ---------------------------------------------------------------------------
  logic s1_valid_q;
  logic s2_valid_q;
  logic out_valid_q;
  logic in_fire;
  logic adv1;
  logic adv2;

  assign adv2          = s2_valid_q && (!out_valid_q || m_axis_tready);
  assign adv1          = s1_valid_q && (!s2_valid_q || adv2);
  assign s_axis_tready = !s1_valid_q || adv1;
  assign in_fire       = s_axis_tvalid && s_axis_tready;

  // ---------------------------------------------------------------------------
  // Stream position of the next item
  // ---------------------------------------------------------------------------
  logic [ColW-1:0] col_q;
  logic [RowW-1:0] row_q;
  logic            frame_end;

  // The item at row FRAME_WIDTH+2, column 1 gives the last result of the frame.
  assign frame_end = (row_q == RowEnd) && (col_q == ColOne);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      col_q <= '0;
      row_q <= '0;
    end else if (in_fire) begin
      if (frame_end) begin
        col_q <= '0;
        row_q <= '0;
      end else if (col_q == ColLast) begin
        col_q <= '0;
        row_q <= row_q + RowOne;
      end else begin
        col_q <= col_q + ColOne;
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Input decode: binary bit and border flags of the windows this item closes
  // ---------------------------------------------------------------------------
  // The edge window is centered one row and one pixel behind the item, the
  // output window one row and one pixel behind that.
  logic            col_ge1;
  logic            col_ge2;
  logic            in_bit;
  logic [ColW-1:0] in_ecol;
  border_t         in_ebord;
  border_t         in_obord;
  logic            in_out_en;

  always_comb begin
    col_ge1 = (col_q != '0);
    col_ge2 = (col_q >= ColTwo);

    // Pad items and items beyond the frame count as black.
    in_bit = (row_q < RowPast) && !s_axis_tuser && (s_axis_tdata > thresh_q);

    in_ecol = col_ge1 ? (col_q - ColOne) : ColLast;

    in_ebord.top    = col_ge1 ? (row_q == RowOne)  : (row_q == RowTwo);
    in_ebord.bottom = col_ge1 ? (row_q == RowPast) : (row_q == RowBelow);
    in_ebord.left   = (col_q == ColOne);
    in_ebord.right  = (col_q == '0);

    in_obord.top    = col_ge2 ? (row_q == RowTwo)   : (row_q == RowThree);
    in_obord.bottom = col_ge2 ? (row_q == RowBelow) : (row_q == RowEnd);
    in_obord.left   = (col_q == ColTwo);
    in_obord.right  = (col_q == ColOne);

    // Results start 2*FRAME_WIDTH+2 items into the frame.
    in_out_en = (row_q > RowTwo) || ((row_q == RowTwo) && col_ge2);
  end

  // ---------------------------------------------------------------------------
  // Stage 1: accepted item, binary line store read in flight
  // ---------------------------------------------------------------------------
  logic            s1_bit_q;
  logic [ColW-1:0] s1_col_q;
  logic [ColW-1:0] s1_ecol_q;
  border_t         s1_ebord_q;
  border_t         s1_obord_q;
  logic            s1_out_en_q;
  logic            s1_last_q;
  logic [1:0]      bin_rd;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else if (in_fire) begin
      s1_valid_q <= 1'b1;
    end else if (adv1) begin
      s1_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      s1_bit_q    <= in_bit;
      s1_col_q    <= col_q;
      s1_ecol_q   <= in_ecol;
      s1_ebord_q  <= in_ebord;
      s1_obord_q  <= in_obord;
      s1_out_en_q <= in_out_en;
      s1_last_q   <= frame_end;
    end
  end

  // Rotate the column on the way back: one row back moves to two rows back.
  bsed_line_store #(
    .Depth(FRAME_WIDTH)
  ) u_bin_store (
    .clk_i     (clk_i),
    .rd_en_i   (in_fire),
    .rd_addr_i (col_q),
    .rd_data_o (bin_rd),
    .wr_en_i   (adv1),
    .wr_addr_i (s1_col_q),
    .wr_data_i ({bin_rd[0], s1_bit_q})
  );

  // ---------------------------------------------------------------------------
  // Stage 2: binary window, edge decision, edge line store read in flight
  // ---------------------------------------------------------------------------
  logic [8:0]      bwin_q;
  logic [8:0]      bwin_d;
  logic [ColW-1:0] s2_col_q;
  border_t         s2_ebord_q;
  border_t         s2_obord_q;
  logic            s2_out_en_q;
  logic            s2_last_q;
  logic [1:0]      edge_rd;
  logic            edge_bit;

  // Shift left and bring in the new column: two rows back, one row back, now.
  always_comb begin
    bwin_d = {bin_rd[0] ? 1'b0 : 1'b0, 8'h00};
    bwin_d = {s1_bit_q, bwin_q[8:7], bin_rd[0], bwin_q[5:4], bin_rd[1], bwin_q[2:1]};
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s2_valid_q <= 1'b0;
    end else if (adv1) begin
      s2_valid_q <= 1'b1;
    end else if (adv2) begin
      s2_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv1) begin
      bwin_q      <= bwin_d;
      s2_col_q    <= s1_ecol_q;
      s2_ebord_q  <= s1_ebord_q;
      s2_obord_q  <= s1_obord_q;
      s2_out_en_q <= s1_out_en_q;
      s2_last_q   <= s1_last_q;
    end
  end

  assign edge_bit = sobel_nonzero(mask_window(bwin_q, s2_ebord_q));

  bsed_line_store #(
    .Depth(FRAME_WIDTH)
  ) u_edge_store (
    .clk_i     (clk_i),
    .rd_en_i   (adv1),
    .rd_addr_i (s1_ecol_q),
    .rd_data_o (edge_rd),
    .wr_en_i   (adv2),
    .wr_addr_i (s2_col_q),
    .wr_data_i ({edge_rd[0], edge_bit})
  );

  // ---------------------------------------------------------------------------
  // Edge window and output register
  // ---------------------------------------------------------------------------
  logic [8:0] ewin_q;
  logic [8:0] ewin_d;
  logic [8:0] ewin_m;
  logic       joined;
  logic [7:0] out_data_q;
  logic       out_last_q;

  always_comb begin
    ewin_d = {edge_bit, ewin_q[8:7], edge_rd[0], ewin_q[5:4], edge_rd[1], ewin_q[2:1]};
    ewin_m = mask_window(ewin_d, s2_obord_q);
    // Center is an edge and so is one of its four direct neighbors.
    joined = ewin_m[4] && (ewin_m[1] || ewin_m[7] || ewin_m[3] || ewin_m[5]);
  end

  always_ff @(posedge clk_i) begin
    if (adv2) begin
      ewin_q     <= ewin_d;
      out_data_q <= joined ? PixelBlack : PixelWhite;
      out_last_q <= s2_last_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (adv2) begin
      out_valid_q <= s2_out_en_q;
    end else if (m_axis_tready) begin
      out_valid_q <= 1'b0;
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = out_data_q;
  assign m_axis_tlast  = out_last_q;

endmodule

[sv/bsed_checker.sv]
module bsed_checker
  import bsed_pkg::*;
(
  input logic       clk_i,
  input logic       rst_ni,
  input logic       s_axis_tready,
  input logic       m_axis_tvalid,
  input logic       m_axis_tready,
  input logic [7:0] m_axis_tdata,
  input logic       m_axis_tlast
);

  // A stalled result holds its value.
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=>
      m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tlast))
    else $error("stalled output item changed");

  a_out_levels: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> (m_axis_tdata == PixelBlack) || (m_axis_tdata == PixelWhite))
    else $error("output pixel is neither black nor white");

  // Input backpressure only comes from a stalled output.
  a_ready_stall: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !s_axis_tready |-> m_axis_tvalid && !m_axis_tready)
    else $error("input stalled while output is free");

  a_ready_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(m_axis_tvalid && !m_axis_tready) |-> s_axis_tready)
    else $error("input not ready although output moves");

endmodule

bind binary_sobel_edge_detect_top bsed_checker u_bsed_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .s_axis_tready (s_axis_tready),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready),
  .m_axis_tdata  (m_axis_tdata),
  .m_axis_tlast  (m_axis_tlast)
);
